// ===== rtl/ks_pkg.sv =====
// ks_pkg: word types and cell control struct for the key sorter
// no dependencies; used by ks_cell and key_sorter
package ks_pkg;

    localparam int FIELD_BITS = 32;

    typedef struct packed {
        logic [FIELD_BITS-1:0] key;
        logic                  last;
    } t_in_word;

    typedef struct packed {
        logic [FIELD_BITS-1:0] sorted_key;
        logic                  final_res;
        logic                  overflow;
    } t_out_word;

    typedef struct packed {
        logic ins;
        logic pop;
        logic sgn;
    } t_cell_ctl;

endpackage

// ===== rtl/ks_cell.sv =====
// ks_cell: one slot of the insertion chain, holds a key and its valid bit
// depends on ks_pkg (t_cell_ctl)
module ks_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ks_pkg::t_cell_ctl     i_ctl,
    input  logic [KEY_BITS-1:0]   i_new_key,
    input  logic                  i_prev_above,
    input  logic                  i_prev_valid,
    input  logic [KEY_BITS-1:0]   i_prev_key,
    input  logic                  i_next_valid,
    input  logic [KEY_BITS-1:0]   i_next_key,
    output logic                  o_above,
    output logic                  o_valid,
    output logic [KEY_BITS-1:0]   o_key
);

    logic                r_valid;
    logic                n_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic [KEY_BITS-1:0] w_flip;

    // sign bit flip turns two's complement order into unsigned order
    assign w_flip  = {i_ctl.sgn, {(KEY_BITS-1){1'b0}}};
    assign o_above = !r_valid || ((r_key ^ w_flip) > (i_new_key ^ w_flip));

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        if (i_ctl.pop) begin
            n_valid = i_next_valid;
            n_key   = i_next_key;
        end else if (i_ctl.ins && o_above) begin
            if (i_prev_above) begin
                n_valid = i_prev_valid;
                n_key   = i_prev_key;
            end else begin
                n_valid = 1'b1;
                n_key   = i_new_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;

endmodule

// ===== rtl/key_sorter.sv =====
// key_sorter: top level, a chain of COUNT insertion cells that sorts while loading
// depends on ks_pkg and ks_cell
//
//  channel   direction  handshake                 word
//  in        sink       i_in_valid / o_in_ready   t_in_word  (key, last)
//  out       source     o_out_valid / i_out_ready t_out_word (sorted_key, final_res, overflow)
//  cfg       sink       i_cfg_we                  i_cfg_data (signed_compare)
//
// load: one key per cycle if not draining, inserted in the cycle it arrives unless the chain is full
// drain: one key per cycle from cell 0 when ready, the chain shifts down on each taken word
// a run loads all its keys, then drains them; no input is taken while draining
// synchronous active-low reset empties the chain and clears the mode bit
// a stalled output holds cell 0 and the whole chain in place
module key_sorter #(
    parameter int COUNT    = 64,
    parameter int KEY_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ks_pkg::t_in_word  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ks_pkg::t_out_word o_out_word,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data
);

    localparam int WIDE_BITS = (KEY_BITS > ks_pkg::FIELD_BITS) ? KEY_BITS : ks_pkg::FIELD_BITS;

    logic                r_draining;
    logic                r_overflow;
    logic                r_signed;
    logic                w_accept;
    logic                w_pop;
    logic                w_full;
    ks_pkg::t_cell_ctl   w_ctl;
    logic [WIDE_BITS-1:0] w_in_wide;
    logic [WIDE_BITS-1:0] w_out_wide;
    logic [KEY_BITS-1:0] w_new_key;
    logic [COUNT-1:0]    w_valid;
    logic [COUNT-1:0]    w_above;
    logic [KEY_BITS-1:0] w_key [COUNT];

    assign w_in_wide  = WIDE_BITS'(i_in_word.key);
    assign w_new_key  = w_in_wide[KEY_BITS-1:0];
    assign w_full     = w_valid[COUNT-1];
    assign o_in_ready = !r_draining;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_draining;
    assign w_pop      = o_out_valid && i_out_ready;

    assign w_ctl.ins = w_accept && !w_full;
    assign w_ctl.pop = w_pop;
    assign w_ctl.sgn = r_signed;

    genvar g;
    generate
        for (g = 0; g < COUNT; g++) begin : g_cell
            ks_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_new_key    (w_new_key),
                .i_prev_above ((g == 0) ? 1'b0 : w_above[(g == 0) ? 0 : g-1]),
                .i_prev_valid ((g == 0) ? 1'b0 : w_valid[(g == 0) ? 0 : g-1]),
                .i_prev_key   (w_key[(g == 0) ? 0 : g-1]),
                .i_next_valid ((g == COUNT-1) ? 1'b0 : w_valid[(g == COUNT-1) ? g : g+1]),
                .i_next_key   (w_key[(g == COUNT-1) ? g : g+1]),
                .o_above      (w_above[g]),
                .o_valid      (w_valid[g]),
                .o_key        (w_key[g])
            );
        end
    endgenerate

    assign w_out_wide            = WIDE_BITS'(w_key[0]);
    assign o_out_word.sorted_key = w_out_wide[ks_pkg::FIELD_BITS-1:0];
    assign o_out_word.final_res  = !w_valid[1];
    assign o_out_word.overflow   = r_overflow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_overflow <= 1'b0;
            r_signed   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_signed <= i_cfg_data;
            end
            if (w_accept) begin
                if (w_full) begin
                    r_overflow <= 1'b1;
                end
                if (i_in_word.last) begin
                    r_draining <= 1'b1;
                end
            end else if (w_pop && o_out_word.final_res) begin
                r_draining <= 1'b0;
                r_overflow <= 1'b0;
            end
        end
    end

    // occupied cells always form a prefix of the chain
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + COUNT'(1))) == '0)
        else $error("gap in cell chain");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> w_valid[0])
        else $error("draining with empty chain");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && o_out_word.final_res) |=> (!r_draining && w_valid == '0 && !r_overflow))
        else $error("run did not end cleanly");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (w_full || r_draining))
        else $error("overflow without full chain");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("load and drain at once");

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for key_sorter, the run sorter with signed or unsigned order
// depends on ks_pkg and key_sorter; directed runs (corners, overflow), then random runs
// an in-bench sorter predicts each run's output words, which are checked as they drain
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT      = 64;
    localparam int KEY_BITS   = 32;
    localparam int IDLE_LIMIT = 1000;
    localparam int unsigned ITEM_TARGET = 220;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

    typedef enum int unsigned {
        KEYS_ANY,
        KEYS_SMALL,
        KEYS_NEAR_SIGN,
        KEYS_CORNERS,
        KEYS_MIXED
    } t_key_style;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    ks_pkg::t_in_word  in_word = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    ks_pkg::t_out_word out_word;
    logic              cfg_we = 1'b0;
    logic              cfg_data = 1'b0;

    logic              signed_mode = 1'b0;
    logic [31:0]       held_keys [$];
    logic              run_dropped = 1'b0;
    ks_pkg::t_out_word sorted_words_due [$];

    int          mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned items_sent = 0;
    int unsigned words_taken = 0;
    int unsigned words_seen = 0;
    int unsigned sink_stall = 0;
    logic        sink_burst = 1'b0;
    logic        send_burst = 1'b0;

    key_sorter #(
        .COUNT    (COUNT),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] order_rank(input logic [31:0] k);
        return signed_mode ? (k ^ SIGN_BIT) : k;
    endfunction

    // keeps up to COUNT of the run's keys and, on the last one, queues the ascending words
    task automatic sort_on_last(input logic [31:0] key, input logic last);
        logic [31:0]       ordered [$];
        logic [31:0]       v;
        ks_pkg::t_out_word w;
        int                i;
        int                j;
        if (held_keys.size() < COUNT) begin
            held_keys.push_back(key);
        end else begin
            run_dropped = 1'b1;
        end
        if (last) begin
            for (i = 0; i < held_keys.size(); i++) begin
                v = held_keys[i];
                j = 0;
                while (j < ordered.size() && order_rank(ordered[j]) <= order_rank(v)) j++;
                ordered.insert(j, v);
            end
            for (i = 0; i < ordered.size(); i++) begin
                w.sorted_key = ordered[i];
                w.final_res  = (i == ordered.size() - 1);
                w.overflow   = run_dropped;
                sorted_words_due.push_back(w);
            end
            held_keys.delete();
            run_dropped = 1'b0;
        end
    endtask

    task automatic send_key(input logic [31:0] key, input logic last);
        int unsigned gap;
        gap = send_burst ? 0 : $urandom_range(8, 0);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= ks_pkg::t_in_word'{key: key, last: last};
        do @(posedge clk); while (!in_ready);
        items_sent++;
        sort_on_last(key, last);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sorted_words_due.size() != 0) @(posedge clk);
    endtask

    task automatic set_compare_mode(input logic sgn);
        wait_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= sgn;
        @(negedge clk);
        cfg_we   <= 1'b0;
        signed_mode = sgn;
    endtask

    function automatic logic [31:0] draw_key(input t_key_style style);
        logic [31:0] corners [0:3];
        corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        case (style)
            KEYS_SMALL:     return $urandom_range(15, 0);
            KEYS_NEAR_SIGN: return SIGN_BIT - 32'd8 + $urandom_range(15, 0);
            KEYS_CORNERS:   return corners[$urandom_range(3, 0)];
            KEYS_MIXED:     return draw_key(t_key_style'($urandom_range(3, 0)));
            default:        return $urandom();
        endcase
    endfunction

    task automatic send_random_run(input int unsigned len, input t_key_style style);
        int unsigned k;
        for (k = 0; k < len; k++) send_key(draw_key(style), k == len - 1);
    endtask

    task automatic send_corner_run();
        logic [31:0] corner_keys [0:7];
        int          k;
        corner_keys = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                        32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFF};
        for (k = 0; k < 8; k++) send_key(corner_keys[k], k == 7);
    endtask

    task automatic test_single_key();
        send_key(32'h0000_0000, 1'b1);
        send_key(32'hFFFF_FFFF, 1'b1);
        send_key(32'h8000_0000, 1'b1);
    endtask

    task automatic test_unsigned_corners();
        set_compare_mode(1'b0);
        send_corner_run();
    endtask

    task automatic test_signed_corners();
        set_compare_mode(1'b1);
        send_corner_run();
    endtask

    task automatic test_equal_keys();
        send_key(32'hA5A5_A5A5, 1'b0);
        send_key(32'hA5A5_A5A5, 1'b0);
        send_key(32'hA5A5_A5A5, 1'b1);
    endtask

    // past capacity the last word is itself dropped but still closes the run
    task automatic test_overflow();
        set_compare_mode(1'b0);
        send_random_run(COUNT + 3, KEYS_ANY);
        set_compare_mode(1'b1);
        send_burst = 1'b1;
        send_random_run(COUNT, KEYS_MIXED);
        send_burst = 1'b0;
    endtask

    // second run held off by in_ready until the first has fully drained, and paused mid-way
    task automatic test_drain_pause();
        int unsigned k;
        send_random_run(5, KEYS_ANY);
        for (k = 0; k < 3; k++) send_key(draw_key(KEYS_ANY), 1'b0);
        wait_drained();
        send_random_run(4, KEYS_SMALL);
    endtask

    task automatic test_random_runs();
        int unsigned runs;
        int unsigned len;
        int unsigned pick;
        runs = 0;
        while (items_sent < ITEM_TARGET) begin
            if (runs % 6 == 5) set_compare_mode(1'($urandom_range(1, 0)));
            pick = $urandom_range(19, 0);
            if (pick == 0) begin
                len = $urandom_range(COUNT + 4, COUNT - 2);
            end else if (pick < 4) begin
                len = $urandom_range(40, 13);
            end else begin
                len = $urandom_range(12, 1);
            end
            if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
            send_burst = ($urandom_range(3, 0) == 0);
            send_random_run(len, t_key_style'($urandom_range(4, 0)));
            runs++;
        end
        send_burst = 1'b0;
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_single_key();
        test_unsigned_corners();
        test_signed_corners();
        test_equal_keys();
        test_overflow();
        test_drain_pause();
        test_random_runs();
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && sorted_words_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // a fresh stall is drawn after every taken word
    always @(negedge clk) begin
        if (words_seen != words_taken) begin
            words_seen = words_taken;
            if ($urandom_range(15, 0) == 0) sink_burst = !sink_burst;
            sink_stall = sink_burst ? 0 : $urandom_range(8, 0);
        end
        if (sink_stall != 0) begin
            out_ready <= 1'b0;
            sink_stall--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : check_words
        ks_pkg::t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (sorted_words_due.size() == 0) begin
                $error("unexpected word: sorted_key %h", out_word.sorted_key);
                mismatches++;
            end else begin
                want = sorted_words_due.pop_front();
                if (out_word.sorted_key !== want.sorted_key) begin
                    $error("sorted_key: expected %h, got %h", want.sorted_key,
                           out_word.sorted_key);
                    mismatches++;
                end
                if (out_word.final_res !== want.final_res) begin
                    $error("final_res: expected %b, got %b", want.final_res,
                           out_word.final_res);
                    mismatches++;
                end
                if (out_word.overflow !== want.overflow) begin
                    $error("overflow: expected %b, got %b", want.overflow,
                           out_word.overflow);
                    mismatches++;
                end
            end
            words_taken++;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/ks_pkg.sv
rtl/ks_cell.sv
rtl/key_sorter.sv
verif/tb_top.sv
